FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL (included by the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define CHK_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication, checked during reset too.
`define CHK_NXT_ANY(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/tals_pkg.sv
package tals_pkg;

  localparam int POS_BITS = 16;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RAISE = 2'd1;
  localparam logic [1:0] PH_LINE  = 2'd2;
  localparam logic [1:0] PH_LOWER = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic               z_limit_clear;
  } in_word_t;

  typedef struct packed {
    logic               step_x_pulse;
    logic               x_forward;
    logic               step_y_pulse;
    logic               y_forward;
    logic               step_z_pulse;
    logic               z_upward;
    logic [1:0]         motion_phase;
    logic               move_done;
    logic signed [15:0] now_x;
    logic signed [15:0] now_y;
    logic signed [15:0] now_z;
  } out_word_t;

  typedef logic signed [POS_BITS-1:0] pos_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic is_start;
    pos_t goal_x;
    pos_t goal_y;
    pos_t goal_z;
    logic clear;
  } cmd_t;

  // Queue handshake seen by the consumer.
  typedef struct packed {
    logic avail;
    logic full;
  } q_stat_t;

  function automatic pos_t to_pos(logic signed [15:0] v);
    return pos_t'(v);
  endfunction

endpackage

FILE: rtl/tals_front.sv
module tals_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tals_pkg::in_word_t word,
  input  logic              take,
  output tals_pkg::q_stat_t stat,
  output tals_pkg::cmd_t    cmd
);
  import tals_pkg::*;

  cmd_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       decoded;

  assign stat.full  = (count == 2'd2);
  assign stat.avail = (count != 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = take && stat.avail;
  assign cmd        = slots[rd_ptr];

  // Classify and convert targets to the position type (same width).
  always_comb begin
    decoded.is_start = (word.operation == OP_START);
    decoded.goal_x   = to_pos(word.target_x);
    decoded.goal_y   = to_pos(word.target_y);
    decoded.goal_z   = to_pos(word.target_z);
    decoded.clear    = word.z_limit_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= decoded;
  end

endmodule

FILE: rtl/tals_back.sv
module tals_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  tals_pkg::cmd_t     cmd,
  output tals_pkg::out_word_t res
);
  import tals_pkg::*;

  localparam int P = POS_BITS;

  pos_t           pos_x, pos_y, pos_z, goal_z;
  logic [P-1:0]   span_x, span_y, major_count, iterations_done;
  logic [P:0]     accum_x, accum_y;
  logic [1:0]     dir_bits;
  logic [1:0]     phase;
  // Line setup worked out when the start is taken; XY hold still until the line phase.
  logic [P-1:0]   pend_span_x, pend_span_y, pend_major;
  logic [1:0]     pend_dir;

  pos_t           pos_x_next, pos_y_next, pos_z_next, goal_z_next;
  logic [P-1:0]   span_x_next, span_y_next, major_count_next, iterations_done_next;
  logic [P:0]     accum_x_next, accum_y_next;
  logic [1:0]     dir_bits_next, phase_next;
  logic [P-1:0]   pend_span_x_next, pend_span_y_next, pend_major_next;
  logic [1:0]     pend_dir_next;
  logic           sx, sy, sz, zup, done;

  always_comb begin
    logic signed [P:0] dx;
    logic signed [P:0] dy;
    logic [P-1:0]      mx;
    logic [P-1:0]      my;
    pos_x_next           = pos_x;
    pos_y_next           = pos_y;
    pos_z_next           = pos_z;
    goal_z_next          = goal_z;
    span_x_next          = span_x;
    span_y_next          = span_y;
    major_count_next     = major_count;
    iterations_done_next = iterations_done;
    accum_x_next         = accum_x;
    accum_y_next         = accum_y;
    dir_bits_next        = dir_bits;
    phase_next           = phase;
    pend_span_x_next     = pend_span_x;
    pend_span_y_next     = pend_span_y;
    pend_major_next      = pend_major;
    pend_dir_next        = pend_dir;
    sx   = 1'b0;
    sy   = 1'b0;
    sz   = 1'b0;
    zup  = 1'b0;
    done = 1'b0;
    dx = {cmd.goal_x[P-1], cmd.goal_x} - {pos_x[P-1], pos_x};
    dy = {cmd.goal_y[P-1], cmd.goal_y} - {pos_y[P-1], pos_y};
    mx = dx[P] ? P'(-dx) : P'(dx);
    my = dy[P] ? P'(-dy) : P'(dy);

    if (cmd.is_start) begin
      if (phase == PH_IDLE) begin
        goal_z_next      = cmd.goal_z;
        pend_span_x_next = mx;
        pend_span_y_next = my;
        pend_major_next  = (mx > my) ? mx : my;
        pend_dir_next    = {!dy[P] && (dy != '0), !dx[P] && (dx != '0)};
        phase_next       = PH_RAISE;
      end
    end else begin
      if (phase_next == PH_RAISE) begin
        if (pos_z[P-1] && cmd.clear) begin
          pos_z_next = pos_z + P'(1);
          sz  = 1'b1;
          zup = 1'b1;
        end else begin
          span_x_next          = pend_span_x;
          span_y_next          = pend_span_y;
          major_count_next     = pend_major;
          dir_bits_next        = pend_dir;
          accum_x_next         = '0;
          accum_y_next         = '0;
          iterations_done_next = '0;
          phase_next           = PH_LINE;
        end
      end
      if (phase_next == PH_LINE) begin
        if (iterations_done_next < major_count_next) begin
          if (span_x_next != '0) begin
            accum_x_next = accum_x_next + {1'b0, span_x_next};
            if (accum_x_next >= {1'b0, major_count_next}) begin
              accum_x_next = accum_x_next - {1'b0, major_count_next};
              pos_x_next   = dir_bits_next[0] ? pos_x + P'(1) : pos_x - P'(1);
              sx = 1'b1;
            end
          end
          if (span_y_next != '0) begin
            accum_y_next = accum_y_next + {1'b0, span_y_next};
            if (accum_y_next >= {1'b0, major_count_next}) begin
              accum_y_next = accum_y_next - {1'b0, major_count_next};
              pos_y_next   = dir_bits_next[1] ? pos_y + P'(1) : pos_y - P'(1);
              sy = 1'b1;
            end
          end
          iterations_done_next = iterations_done_next + P'(1);
        end else begin
          phase_next = PH_LOWER;
        end
      end
      if (phase_next == PH_LOWER) begin
        if ((pos_z_next > goal_z) && cmd.clear) begin
          pos_z_next = pos_z_next - P'(1);
          sz = 1'b1;
        end else begin
          phase_next = PH_IDLE;
          done = 1'b1;
        end
      end
    end

    res.step_x_pulse = sx;
    res.x_forward    = dir_bits_next[0];
    res.step_y_pulse = sy;
    res.y_forward    = dir_bits_next[1];
    res.step_z_pulse = sz;
    res.z_upward     = zup;
    res.motion_phase = phase_next;
    res.move_done    = done;
    res.now_x        = 16'(pos_x_next);
    res.now_y        = 16'(pos_y_next);
    res.now_z        = 16'(pos_z_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x           <= '0;
      pos_y           <= '0;
      pos_z           <= '0;
      goal_z          <= '0;
      span_x          <= '0;
      span_y          <= '0;
      major_count     <= '0;
      iterations_done <= '0;
      accum_x         <= '0;
      accum_y         <= '0;
      dir_bits        <= '0;
      phase           <= PH_IDLE;
      pend_span_x     <= '0;
      pend_span_y     <= '0;
      pend_major      <= '0;
      pend_dir        <= '0;
    end else if (fire) begin
      pos_x           <= pos_x_next;
      pos_y           <= pos_y_next;
      pos_z           <= pos_z_next;
      goal_z          <= goal_z_next;
      span_x          <= span_x_next;
      span_y          <= span_y_next;
      major_count     <= major_count_next;
      iterations_done <= iterations_done_next;
      accum_x         <= accum_x_next;
      accum_y         <= accum_y_next;
      dir_bits        <= dir_bits_next;
      phase           <= phase_next;
      pend_span_x     <= pend_span_x_next;
      pend_span_y     <= pend_span_y_next;
      pend_major      <= pend_major_next;
      pend_dir        <= pend_dir_next;
    end
  end

endmodule

FILE: rtl/tals_result_q.sv
module tals_result_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                put,
  input  tals_pkg::out_word_t put_word,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tals_pkg::out_word_t word
);
  import tals_pkg::*;

  out_word_t  slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_put;
  logic       do_pop;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign do_put = put && !full;
  assign do_pop = pop && !empty;
  assign word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_put) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_put) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_put) slots[wr_ptr] <= put_word;
  end

endmodule

FILE: rtl/three_axis_lift_and_line_stepper_top.sv
// A pushed word is registered in the front queue, then its result in the result queue
// when the engine fires. Throughput: one word per cycle while the result queue has room;
// each tick runs its whole phase update, line step add and compare included, combinationally.
// Reset: rst is synchronous, active high; it empties both queues and clears positions,
// targets, line state and phase to zero (idle). No clearing pass follows.
`include "assert_macros.svh"

module three_axis_lift_and_line_stepper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tals_pkg::in_word_t  command,
  output logic                empty,
  input  logic                pop,
  output tals_pkg::out_word_t result
);
  import tals_pkg::*;

  q_stat_t   cmd_stat;
  cmd_t      cmd;
  out_word_t back_word;
  logic      res_full;
  logic      fire;

  // Front: classify each word (start or tick) and hold it in a two-entry queue.
  tals_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .word (command),
    .take (fire),
    .stat (cmd_stat),
    .cmd  (cmd)
  );

  assign full = cmd_stat.full;

  // Back: advance the move by one word whenever a command waits and the
  // result queue has room. The result queue parts the engine from pop, so
  // a stalled reader never blocks the front until both queues fill.
  assign fire = cmd_stat.avail && !res_full;

  tals_back u_back (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (cmd),
    .res  (back_word)
  );

  // Result queue: hold finished words until popped, oldest first.
  tals_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .put      (fire),
    .put_word (back_word),
    .full     (res_full),
    .pop      (pop),
    .empty    (empty),
    .word     (result)
  );

  // A finished move always reports the idle phase.
  `CHK_IMP(a_done_idle, clk, rst, !empty && result.move_done, result.motion_phase == PH_IDLE)
  // An upward Z flag only comes with a Z step.
  `CHK_IMP(a_zup_step, clk, rst, !empty && result.z_upward, result.step_z_pulse)
  // The engine only fires into a queue with room, so a fire always leaves a word waiting.
  `CHK_NXT(a_fire_lands, clk, rst, fire, !empty)
  // Reset leaves nothing to pop.
  `CHK_NXT_ANY(a_rst_empty, clk, rst, empty)

endmodule
